/* rtl/sbq_pkg.sv */
// Shared types, constants and helper functions for the stereo biquad equalizer.
`timescale 1ns / 1ps
package sbq_pkg;

  localparam int BANDS       = 8;
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 32;
  localparam int COEF_FRAC   = COEF_BITS - 5;
  localparam int NCELL       = 2 * BANDS;
  localparam int CIDX_BITS   = $clog2(NCELL * 5);
  localparam int HIDX_BITS   = $clog2(NCELL * 4);
  localparam int CELL_BITS   = $clog2(NCELL);
  localparam int ACC_BITS    = 32 + COEF_BITS + 4;

  localparam logic OP_PROCESS = 1'b0;
  localparam logic OP_COEF    = 1'b1;

  localparam logic [2:0] REG_MS    = 3'd0;
  localparam logic [2:0] REG_GAIN  = 3'd1;
  localparam logic [2:0] REG_TRIM  = 3'd2;
  localparam logic [2:0] REG_EN    = 3'd3;
  localparam logic [2:0] REG_SOLO  = 3'd4;
  localparam logic [2:0] REG_MUTE  = 3'd5;

  typedef struct packed {
    logic                          opcode;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          coef_channel;
    logic [2:0]                    coef_band;
    logic [2:0]                    coef_slot;
    logic signed [COEF_BITS-1:0]   coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          clipped;
  } out_item_t;

  // Datapath operation selected by the controller for one cycle.
  typedef enum logic [3:0] {
    DP_NOP, DP_COEF_WR, DP_GAIN_L, DP_GAIN_R, DP_ENCODE, DP_BAND_CLR, DP_MAC,
    DP_BAND_END, DP_NEXT_CH, DP_DECODE, DP_TRIM_L, DP_TRIM_R
  } dp_op_e;

  typedef struct packed {
    dp_op_e               op;
    logic [CELL_BITS-1:0] cell_idx;
    logic [2:0]           slot;
  } dp_cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647)       return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

endpackage

/* rtl/sbq_datapath.sv */
// Datapath: coefficient memory, history memory, shared multiplier and accumulator.
`timescale 1ns / 1ps
module sbq_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbq_pkg::dp_cmd_t  cmd_i,
  input  sbq_pkg::in_item_t item_i,
  input  logic              ms_i,
  input  logic [15:0]       gain_i,
  input  logic [15:0]       trim_i,
  output sbq_pkg::out_item_t result_o
);
  import sbq_pkg::*;

  // Valid bits give the reset values without a clearing pass.
  logic signed [COEF_BITS-1:0] coef_mem [NCELL*5];
  logic [NCELL*5-1:0]          coef_vld_q;
  logic signed [31:0]          hist_mem [NCELL*4];
  logic [NCELL*4-1:0]          hist_vld_q;

  logic signed [31:0] l_q, r_q, v_q, y_q;
  logic signed [COEF_BITS-1:0] c_rd_q;
  logic signed [31:0]          h_rd_q;
  logic signed [ACC_BITS-1:0]  acc_q;
  logic                        clip_q;
  logic signed [SAMPLE_BITS-1:0] lo_q, ro_q;
  logic [2:0] slot_q;
  logic mac_q;

  // Old x1 and y1 captured during the MAC pass, for the history shift.
  logic signed [31:0] h_shadow0, h_shadow2;

  logic [CIDX_BITS-1:0] cwa, cra;
  logic [HIDX_BITS-1:0] hra;
  assign cwa = CIDX_BITS'({item_i.coef_channel, item_i.coef_band[CELL_BITS-2:0]} * 5
                          + item_i.coef_slot);
  assign cra = CIDX_BITS'(cmd_i.cell_idx * 5 + cmd_i.slot);
  assign hra = HIDX_BITS'(cmd_i.cell_idx * 4 + (cmd_i.slot - 3'd1));

  logic signed [COEF_BITS-1:0] c_rd;
  logic signed [31:0]          h_rd;
  logic signed [31:0]          y_sat;
  logic signed [ACC_BITS-1:0]  prod, shifted;
  logic signed [31:0]          opnd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_COEF_WR) coef_mem[cwa] <= item_i.coef_value;
    c_rd <= coef_mem[cra];
    h_rd <= hist_mem[hra];
    if (cmd_i.op == DP_BAND_END) begin
      hist_mem[HIDX_BITS'(cmd_i.cell_idx * 4 + 1)] <= h_shadow0;
      hist_mem[HIDX_BITS'(cmd_i.cell_idx * 4)]     <= v_q;
    end else if (cmd_i.op == DP_NEXT_CH) begin
      hist_mem[HIDX_BITS'(cmd_i.cell_idx * 4 + 3)] <= h_shadow2;
      hist_mem[HIDX_BITS'(cmd_i.cell_idx * 4 + 2)] <= y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
      hist_vld_q <= '0;
      mac_q      <= 1'b0;
    end else begin
      mac_q <= (cmd_i.op == DP_MAC);
      if (cmd_i.op == DP_COEF_WR) coef_vld_q[cwa] <= 1'b1;
      if (cmd_i.op == DP_BAND_END) begin
        hist_vld_q[HIDX_BITS'(cmd_i.cell_idx * 4)]     <= 1'b1;
        hist_vld_q[HIDX_BITS'(cmd_i.cell_idx * 4 + 1)] <= 1'b1;
      end else if (cmd_i.op == DP_NEXT_CH) begin
        hist_vld_q[HIDX_BITS'(cmd_i.cell_idx * 4 + 2)] <= 1'b1;
        hist_vld_q[HIDX_BITS'(cmd_i.cell_idx * 4 + 3)] <= 1'b1;
      end
    end
  end

  logic cv_q, hv_q;
  always_ff @(posedge clk_i) begin
    slot_q <= cmd_i.slot;
    cv_q   <= coef_vld_q[cra];
    hv_q   <= hist_vld_q[hra];
  end

  always_comb begin
    c_rd_q = cv_q ? c_rd : ((slot_q == 3'd0) ? COEF_BITS'(1) <<< COEF_FRAC : '0);
    h_rd_q = hv_q ? h_rd : '0;
    opnd   = (slot_q == 3'd0) ? v_q : h_rd_q;
    prod   = ACC_BITS'(opnd) * ACC_BITS'(c_rd_q);
    shifted = acc_q >>> COEF_FRAC;
    y_sat  = sat32(64'(shifted));
    if (shifted > ACC_BITS'(64'sd2147483647)) y_sat = 32'sh7fffffff;
    else if (shifted < -ACC_BITS'(64'sd2147483648)) y_sat = 32'sh80000000;
  end

  logic signed [63:0] gl, gr, tl;
  assign gl = (64'(l_q) * $signed({48'd0, gain_i})) >>> 12;
  assign gr = (64'(r_q) * $signed({48'd0, gain_i})) >>> 12;
  assign tl = (64'(v_q) * $signed({48'd0, trim_i})) >>> 12;

  logic signed [63:0] smax;
  assign smax = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;

  always_ff @(posedge clk_i) begin
    if (mac_q) begin
      if (slot_q == 3'd1) h_shadow0 <= h_rd_q;
      if (slot_q == 3'd3) h_shadow2 <= h_rd_q;
      if (slot_q >= 3'd3) acc_q <= acc_q - prod;
      else                acc_q <= acc_q + prod;
    end
    unique case (cmd_i.op)
      DP_GAIN_L: begin
        l_q <= 32'(item_i.left_sample);
        r_q <= 32'(item_i.right_sample);
        clip_q <= 1'b0;
      end
      DP_GAIN_R: begin
        l_q <= sat32(gl);
        r_q <= sat32(gr);
      end
      DP_ENCODE: begin
        if (ms_i) begin
          l_q <= 32'((33'(l_q) + 33'(r_q)) >>> 1);
          r_q <= 32'((33'(l_q) - 33'(r_q)) >>> 1);
        end
        v_q <= ms_i ? 32'((33'(l_q) + 33'(r_q)) >>> 1) : l_q;
      end
      DP_BAND_CLR: acc_q <= '0;
      DP_BAND_END: begin
        y_q <= y_sat;
      end
      DP_NEXT_CH: begin
        v_q <= y_q;
      end
      DP_DECODE: begin
        if (cmd_i.slot == 3'd0) begin
          l_q <= v_q;
          v_q <= r_q;
        end else begin
          if (ms_i) begin
            l_q <= sat32(64'(l_q) + 64'(v_q));
            r_q <= sat32(64'(l_q) - 64'(v_q));
          end else begin
            r_q <= v_q;
          end
        end
      end
      DP_TRIM_L: begin
        if (cmd_i.slot == 3'd0) v_q <= l_q;
        else begin
          if (tl > smax) begin lo_q <= smax[SAMPLE_BITS-1:0]; clip_q <= 1'b1; end
          else if (tl < -smax - 64'sd1) begin
            lo_q <= SAMPLE_BITS'(-smax - 64'sd1); clip_q <= 1'b1;
          end else lo_q <= tl[SAMPLE_BITS-1:0];
          v_q <= r_q;
        end
      end
      DP_TRIM_R: begin
        if (tl > smax) begin ro_q <= smax[SAMPLE_BITS-1:0]; clip_q <= 1'b1; end
        else if (tl < -smax - 64'sd1) begin
          ro_q <= SAMPLE_BITS'(-smax - 64'sd1); clip_q <= 1'b1;
        end else ro_q <= tl[SAMPLE_BITS-1:0];
      end
      default: ;
    endcase
  end

  assign result_o = '{left_out: lo_q, right_out: ro_q, clipped: clip_q};
endmodule

/* rtl/sbq_ctrl.sv */
// Controller: sequences one item through the shared datapath.
`timescale 1ns / 1ps
module sbq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              opcode_i,
  input  logic              band_ok_i,
  input  logic [15:0]       en_i,
  input  logic [15:0]       solo_i,
  input  logic [15:0]       mute_i,
  output sbq_pkg::dp_cmd_t  cmd_o,
  output logic              done_o,
  input  logic              out_busy_i
);
  import sbq_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_G1 = 4'd1, S_G2 = 4'd2, S_ENC = 4'd3,
                         S_BSEL = 4'd4, S_MAC = 4'd5, S_MW1 = 4'd6, S_MW2 = 4'd7,
                         S_END = 4'd8, S_UPD = 4'd9, S_DEC0 = 4'd10, S_DEC1 = 4'd11,
                         S_T0 = 4'd12, S_T1 = 4'd13, S_T2 = 4'd14, S_WAIT = 4'd15;

  logic [3:0]           state_q, state_d;
  logic                 ch_q, ch_d;
  logic [CELL_BITS-1:0] band_q, band_d;
  logic [2:0]           slot_q, slot_d;

  function automatic logic mbit(input logic [15:0] m, input int idx);
    return (idx < 16) ? m[idx[3:0]] : 1'b0;
  endfunction

  logic [CELL_BITS-1:0] cur_cell;
  logic any_solo, run;
  assign cur_cell = CELL_BITS'(ch_q * BANDS + band_q);
  always_comb begin
    any_solo = 1'b0;
    for (int b = 0; b < BANDS; b++)
      any_solo |= mbit(solo_i, int'(ch_q) * BANDS + b);
    run = mbit(en_i, int'(cur_cell)) && !(any_solo && !mbit(solo_i, int'(cur_cell)))
          && !(mbit(mute_i, int'(cur_cell)) && !mbit(solo_i, int'(cur_cell)));
  end

  logic last_band;
  assign last_band = (band_q == CELL_BITS'(BANDS - 1));

  always_comb begin
    state_d = state_q; ch_d = ch_q; band_d = band_q; slot_d = slot_q;
    cmd_o = '{op: DP_NOP, cell_idx: cur_cell, slot: slot_q};
    done_o = 1'b0;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        if (opcode_i == OP_COEF) begin
          if (band_ok_i) cmd_o.op = DP_COEF_WR;
        end else begin
          cmd_o.op = DP_GAIN_L; state_d = S_G1;
        end
      end
      S_G1: begin cmd_o.op = DP_GAIN_R; state_d = S_ENC; end
      S_G2: state_d = S_ENC;
      S_ENC: begin
        cmd_o.op = DP_ENCODE; ch_d = 1'b0; band_d = '0; state_d = S_BSEL;
      end
      S_BSEL: begin
        slot_d = 3'd0;
        if (run) begin cmd_o.op = DP_BAND_CLR; state_d = S_MAC; end
        else if (last_band) state_d = S_UPD;
        else band_d = band_q + 1'b1;
      end
      S_MAC: begin
        // Issue reads; the product of each slot is formed from the registered read data in the next cycle.
        cmd_o.op = DP_MAC;
        if (slot_q == 3'd4) state_d = S_MW1;
        else slot_d = slot_q + 3'd1;
      end
      S_MW1: state_d = S_MW2;
      S_MW2: begin cmd_o.op = DP_BAND_END; state_d = S_END; end
      S_END: begin
        cmd_o.op = DP_NEXT_CH;
        if (last_band) state_d = S_UPD;
        else begin band_d = band_q + 1'b1; state_d = S_BSEL; end
      end
      S_UPD: begin
        cmd_o.op = DP_DECODE; cmd_o.slot = {2'b0, ch_q};
        if (!ch_q) begin ch_d = 1'b1; band_d = '0; state_d = S_BSEL; end
        else state_d = S_T0;
      end
      S_DEC0: state_d = S_T0;
      S_DEC1: state_d = S_T0;
      S_T0: begin cmd_o.op = DP_TRIM_L; cmd_o.slot = 3'd0; state_d = S_T1; end
      S_T1: begin cmd_o.op = DP_TRIM_L; cmd_o.slot = 3'd1; state_d = S_T2; end
      S_T2: if (!out_busy_i) begin cmd_o.op = DP_TRIM_R; state_d = S_WAIT; end
      S_WAIT: begin done_o = 1'b1; state_d = S_IDLE; end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ch_q <= 1'b0; band_q <= '0; slot_q <= '0;
    end else begin
      state_q <= state_d; ch_q <= ch_d; band_q <= band_d; slot_q <= slot_d;
    end
  end
endmodule

/* rtl/stereo_biquad_cascade_eq_top.sv */
// Top level of the stereo cascaded biquad equalizer.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_item_i) takes one item at a time.
//   Opcode 1 stores one coefficient word if its slot is in range and gives
//   no result; the input is ready again in the next cycle.
//   Opcode 0 processes a stereo pair and gives one result item on the
//   output channel (out_valid_o/out_ready_i/out_item_o).
//   A pair runs through gain, encoding, then the eight bands of each channel
//   in turn, a running band through its five products and a skipped band
//   passed over, with a decode step after each channel, and last the trim.
//   The next pair is taken only once the block is idle again, so pairs do
//   not overlap. The rate is set by the single shared multiply-accumulate
//   unit that takes the five products of a band in turn.
//   A finished result sits in the output register; the next item is taken
//   while it waits, and processing stalls before the final trim only if the
//   receiver still has not taken the previous result.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at
//   once; the user must make them only while the block is idle (not checked).
//   Reset restores unity coefficients, clears history through valid bits,
//   and sets gains to unity; no clearing pass is needed.
module stereo_biquad_cascade_eq_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sbq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sbq_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);
  import sbq_pkg::*;

  logic        ms_q;
  logic [15:0] gain_q, trim_q, en_q, solo_q, mute_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q <= 1'b0; gain_q <= 16'd4096; trim_q <= 16'd4096;
      en_q <= '0; solo_q <= '0; mute_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MS:   ms_q   <= cfg_data_i[0];
        REG_GAIN: gain_q <= cfg_data_i;
        REG_TRIM: trim_q <= cfg_data_i;
        REG_EN:   en_q   <= cfg_data_i;
        REG_SOLO: solo_q <= cfg_data_i;
        REG_MUTE: mute_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dp_cmd_t   cmd;
  out_item_t res;
  logic      done, band_ok;
  in_item_t  item_q;

  assign band_ok = (int'(in_item_i.coef_band) < BANDS) && (in_item_i.coef_slot < 3'd5);

  // Hold the accepted item so the datapath sees it during processing.
  always_ff @(posedge clk_i) if (in_valid_i && in_ready_o) item_q <= in_item_i;

  in_item_t dp_item;
  assign dp_item = (in_ready_o) ? in_item_i : item_q;

  sbq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .opcode_i(in_item_i.opcode), .band_ok_i(band_ok),
    .en_i(en_q), .solo_i(solo_q), .mute_i(mute_q),
    .cmd_o(cmd), .done_o(done), .out_busy_i(out_valid_o && !out_ready_i)
  );

  sbq_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .item_i(dp_item),
    .ms_i(ms_q), .gain_i(gain_q), .trim_i(trim_q), .result_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (done) out_valid_o <= 1'b1;
    else if (out_ready_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) if (done) out_item_o <= res;
endmodule

/* rtl/sbq_checker.sv */
// Port-level checker for the equalizer, bound to the top level.
`timescale 1ns / 1ps
module sbq_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input sbq_pkg::in_item_t in_item_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input sbq_pkg::out_item_t out_item_o
);
  import sbq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.opcode == OP_PROCESS) |=> !in_ready_o)
    else $error("ready right after a sample item");
  a_coef_ready_again: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.opcode == OP_COEF) |=> in_ready_o)
    else $error("not ready after a coefficient item");
  a_no_out_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too soon");
endmodule

bind stereo_biquad_cascade_eq_top sbq_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i, .out_valid_o, .out_ready_i,
  .out_item_o
);
